FILE: rtl/core/iav_pkg.sv
// Package for the indexed array with shift insert block.
// Holds sizes, opcode and status codes, and the command struct for the cell row.
// No dependencies.
package iav_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int ROOM_W     = CNT_W + 1;
	localparam int OP_W       = 4;
	localparam int ST_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 4'd0,
		OP_POP    = 4'd1,
		OP_INSERT = 4'd2,
		OP_ERASE  = 4'd3,
		OP_READ   = 4'd4,
		OP_WRITE  = 4'd5,
		OP_FRONT  = 4'd6,
		OP_BACK   = 4'd7,
		OP_CLEAR  = 4'd8
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_INSERT,
		CELL_ERASE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [IDX_W-1:0]      pos;
		logic [CNT_W-1:0]      count;
		logic [DATA_WIDTH-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		status_t           status;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
		logic [CNT_W-1:0]  count;
		logic [ROOM_W-1:0] room;
	} ctrl_res_t;

endpackage

FILE: rtl/core/iav_cell.sv
// One element cell of the shift row.
// Takes data from its own register, its left or right neighbor, or the beat value.
// Depends on iav_pkg.
module iav_cell (
	input  logic                          clk,
	input  logic [iav_pkg::IDX_W-1:0]     idx,
	input  iav_pkg::cell_cmd_t            cmd,
	input  logic [iav_pkg::DATA_WIDTH-1:0] left,
	input  logic [iav_pkg::DATA_WIDTH-1:0] right,
	output logic [iav_pkg::DATA_WIDTH-1:0] data
);
	import iav_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic [CNT_W-1:0]      idx_c;
	logic [CNT_W-1:0]      pos_c;

	assign idx_c = CNT_W'(idx);
	assign pos_c = CNT_W'(cmd.pos);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_PUSH: begin
				if (idx_c == cmd.count) data_q <= cmd.value;
			end
			CELL_INSERT: begin
				if (idx_c == pos_c) data_q <= cmd.value;
				else if (idx_c > pos_c && idx_c <= cmd.count) data_q <= left;
			end
			CELL_ERASE: begin
				if (idx_c >= pos_c && idx_c + CNT_W'(1) < cmd.count) data_q <= right;
			end
			CELL_WRITE: begin
				if (idx_c == pos_c) data_q <= cmd.value;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

FILE: rtl/core/iav_ctrl.sv
// Size and capacity keeper of the array block.
// Checks each operation, drives the cell row command and the result fields.
// Depends on iav_pkg.
module iav_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [iav_pkg::OP_W-1:0]       opcode,
	input  logic [iav_pkg::IDX_W-1:0]      position,
	input  logic [iav_pkg::DATA_WIDTH-1:0] value,
	output iav_pkg::cell_cmd_t             cmd,
	output iav_pkg::ctrl_res_t             res
);
	import iav_pkg::*;

	logic [CNT_W-1:0]  count_q;
	logic [ROOM_W-1:0] room_q;
	logic [ROOM_W-1:0] room_grow;
	logic [CNT_W-1:0]  count_dec;
	logic [ROOM_W-1:0] room_shrink;
	logic              in_range;
	logic              empty;
	logic              full;
	cell_op_t          cell_op;

	assign in_range  = CNT_W'(position) < count_q;
	assign empty     = count_q == '0;
	assign full      = count_q >= CNT_W'(DEPTH);
	assign count_dec = count_q - CNT_W'(1);

	always_comb begin
		if (ROOM_W'(count_q) == room_q) begin
			room_grow = (room_q == '0) ? ROOM_W'(1) : {room_q[ROOM_W-2:0], 1'b0};
		end else begin
			room_grow = room_q;
		end
		if ({count_dec, 2'b00} <= (CNT_W + 2)'(room_q)) begin
			room_shrink = {count_dec, 1'b0};
		end else begin
			room_shrink = room_q;
		end
	end

	always_comb begin
		cell_op        = CELL_HOLD;
		res.status     = ST_OK;
		res.rd_en      = 1'b0;
		res.rd_idx     = position;
		res.count      = count_q;
		res.room       = room_q;
		unique case (opcode)
			OP_PUSH: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					cell_op   = CELL_PUSH;
					res.count = count_q + CNT_W'(1);
					res.room  = room_grow;
				end
			end
			OP_POP: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.count = count_dec;
					res.room  = room_shrink;
				end
			end
			OP_INSERT: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else if (full) begin
					res.status = ST_FULL;
				end else begin
					cell_op   = CELL_INSERT;
					res.count = count_q + CNT_W'(1);
					res.room  = room_grow;
				end
			end
			OP_ERASE: begin
				if (!in_range) begin
					res.status = ST_RANGE;
				end else begin
					cell_op   = CELL_ERASE;
					res.count = count_dec;
					res.room  = room_shrink;
				end
			end
			OP_READ: begin
				if (!in_range) res.status = ST_RANGE;
				else res.rd_en = 1'b1;
			end
			OP_WRITE: begin
				if (!in_range) res.status = ST_RANGE;
				else cell_op = CELL_WRITE;
			end
			OP_FRONT: begin
				res.rd_idx = '0;
				if (empty) res.status = ST_EMPTY;
				else res.rd_en = 1'b1;
			end
			OP_BACK: begin
				res.rd_idx = count_dec[IDX_W-1:0];
				if (empty) res.status = ST_EMPTY;
				else res.rd_en = 1'b1;
			end
			OP_CLEAR: begin
				res.count = '0;
				res.room  = '0;
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	assign cmd.op    = accept ? cell_op : CELL_HOLD;
	assign cmd.pos   = position;
	assign cmd.count = count_q;
	assign cmd.value = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			room_q  <= '0;
		end else if (accept) begin
			count_q <= res.count;
			room_q  <= res.room;
		end
	end

endmodule

FILE: rtl/core/indexed_array_with_shift_insert.sv
// Top level of the indexed array with shift insert block.
// Instantiates iav_ctrl and a row of iav_cell; depends on iav_pkg.
//
// Usage: each input beat on the s_ channel carries one operation (push, pop,
// insert, erase, read, write, front, back, clear). Each beat returns exactly one
// result beat on the m_ channel with status, read data, size, capacity and an
// empty flag.
// The result beat is registered and valid in the cycle after the input beat is taken.
// Throughput: one beat per cycle while the receiver does not stall. Insert and
// erase move every element at once through the cell row and do not stall the input.
// The output register parts the two sides: s_tready stays high while the held
// result is taken in the same cycle; when the receiver stalls, the result holds
// and s_tready drops until m_tready returns.
// Reset: size and capacity clear to zero and no result is pending. Element cells
// are not cleared; only entries below the size are ever read.
module indexed_array_with_shift_insert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // opcode[3:0], position[7:4], value[39:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // status[1:0], read_data[33:2], count[38:34],
	                              // reserved_room[44:39], is_empty[45], zero[47:46]
);
	import iav_pkg::*;

	logic                  accept;
	cell_cmd_t             cmd;
	ctrl_res_t             res;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  out_valid_q;
	logic [47:0]           out_data_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	iav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.opcode   (s_tdata[3:0]),
		.position (s_tdata[7:4]),
		.value    (s_tdata[39:8]),
		.cmd      (cmd),
		.res      (res)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end
		iav_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.cmd   (cmd),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	assign rd_data = res.rd_en ? cell_data[res.rd_idx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, (res.count == '0), res.room, res.count, rd_data, res.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: tb/vector_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the indexed array with shift insert block: predicts each result beat
// from the accepted operation beats and checks the beats that come back.
// Depends on iav_pkg.
package vector_check_pkg;
	import iav_pkg::*;

	typedef struct {
		status_t               status;
		logic [DATA_WIDTH-1:0] read_data;
		logic [CNT_W-1:0]      count;
		logic [ROOM_W-1:0]     room;
		logic                  empty;
	} array_result_t;

	class vector_scoreboard;
		logic [DATA_WIDTH-1:0] cells [DEPTH];
		int unsigned           size;
		int unsigned           room;
		array_result_t         awaited [$];
		int                    errors;

		function new();
			size   = 0;
			room   = 0;
			errors = 0;
			foreach (cells[i])
				cells[i] = '0;
		endfunction

		function int unsigned size_now();
			return size;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void grow();
			if (size == room)
				room = (room == 0) ? 1 : 2 * room;
		endfunction

		function void shrink();
			if (size * 4 <= room)
				room = 2 * size;
		endfunction

		function void note_operation(logic [OP_W-1:0] opc, logic [IDX_W-1:0] pos,
				logic [DATA_WIDTH-1:0] val);
			array_result_t r;
			r.status    = ST_OK;
			r.read_data = '0;
			case (opc)
				OP_PUSH: begin
					if (size >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						grow();
						cells[size] = val;
						size++;
					end
				end
				OP_POP: begin
					if (size == 0) begin
						r.status = ST_EMPTY;
					end else begin
						size--;
						shrink();
					end
				end
				OP_INSERT: begin
					if (pos >= size) begin
						r.status = ST_RANGE;
					end else if (size >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						grow();
						for (int i = size; i > pos; i--)
							cells[i] = cells[i-1];
						cells[pos] = val;
						size++;
					end
				end
				OP_ERASE: begin
					if (pos >= size) begin
						r.status = ST_RANGE;
					end else begin
						for (int i = pos; i + 1 < size; i++)
							cells[i] = cells[i+1];
						size--;
						shrink();
					end
				end
				OP_READ: begin
					if (pos >= size)
						r.status = ST_RANGE;
					else
						r.read_data = cells[pos];
				end
				OP_WRITE: begin
					if (pos >= size)
						r.status = ST_RANGE;
					else
						cells[pos] = val;
				end
				OP_FRONT: begin
					if (size == 0)
						r.status = ST_EMPTY;
					else
						r.read_data = cells[0];
				end
				OP_BACK: begin
					if (size == 0)
						r.status = ST_EMPTY;
					else
						r.read_data = cells[size-1];
				end
				OP_CLEAR: begin
					size = 0;
					room = 0;
				end
				default: ;
			endcase
			r.count = size[CNT_W-1:0];
			r.room  = room[ROOM_W-1:0];
			r.empty = (size == 0);
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got, time t);
			if (got !== want) begin
				errors++;
				$display("%0t mismatch on %s: expected %0h, actual %0h", t, name, want, got);
			end
		endfunction

		function void check_result(logic [47:0] beat, time t);
			array_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t result beat with none expected: expected nothing, actual %h",
					t, beat);
				return;
			end
			want = awaited.pop_front();
			compare_field("status", want.status, beat[1:0], t);
			compare_field("read_data", want.read_data, beat[33:2], t);
			compare_field("count", want.count, beat[38:34], t);
			compare_field("reserved_room", want.room, beat[44:39], t);
			compare_field("is_empty", want.empty, beat[45], t);
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for indexed_array_with_shift_insert: directed and random
// operation beats under varied stalls, checked by the scoreboard in vector_check_pkg.
// Depends on iav_pkg, vector_check_pkg and the block's RTL.
module tb_top;
	import iav_pkg::*;
	import vector_check_pkg::*;

	localparam int OPCODE_MAX = 15;
	localparam int HOLD_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // opcode[3:0], position[7:4], value[39:8]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // status[1:0], read_data[33:2], count[38:34],
	                        // reserved_room[44:39], is_empty[45], zero[47:46]

	int               send_idle_pct;
	int               recv_idle_pct;
	bit               stall_request;
	vector_scoreboard sb;

	indexed_array_with_shift_insert uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left     = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, $time);
	end

	task automatic send_op(input logic [OP_W-1:0] opc, input logic [IDX_W-1:0] pos,
			input logic [DATA_WIDTH-1:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {val, pos, opc};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_operation(opc, pos, val);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic send_random(input int n);
		logic [OP_W-1:0]       opc;
		logic [IDX_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] val;
		int                    roll;
		int                    size_now;
		bit                    growing;
		growing = 1'b1;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				growing = 1'($urandom_range(0, 1));
			size_now = sb.size_now();
			roll     = $urandom_range(0, 99);
			if (roll < 2)
				opc = OP_W'($urandom_range(OP_CLEAR + 1, OPCODE_MAX));
			else if (roll < 3)
				opc = OP_CLEAR;
			else if (roll < (growing ? 50 : 25))
				opc = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
			else if (roll < 65)
				opc = $urandom_range(0, 1) ? OP_POP : OP_ERASE;
			else begin
				case ($urandom_range(0, 3))
					0:       opc = OP_READ;
					1:       opc = OP_WRITE;
					2:       opc = OP_FRONT;
					default: opc = OP_BACK;
				endcase
			end
			if (size_now > 0 && $urandom_range(0, 9) < 8)
				pos = IDX_W'($urandom_range(0, size_now - 1));
			else
				pos = IDX_W'($urandom());
			case ($urandom_range(0, 9))
				0:       val = '0;
				1:       val = '1;
				default: val = $urandom();
			endcase
			send_op(opc, pos, val);
		end
	endtask

	initial begin : stimulus
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_op(OP_POP, '0, '0);
		send_op(OP_FRONT, '0, '0);
		send_op(OP_BACK, '0, '0);
		send_op(OP_INSERT, '0, 32'hdead_beef);
		send_op(OP_READ, '1, '0);
		send_op(OP_W'(OPCODE_MAX), '1, '1);
		for (int k = 0; k < DEPTH; k++)
			send_op(OP_PUSH, IDX_W'(k), (k == 0) ? '0 : (k == 1) ? '1 : $urandom());
		send_op(OP_PUSH, '0, 32'h1234_5678);
		send_op(OP_INSERT, IDX_W'(5), 32'h8765_4321);
		send_op(OP_CLEAR, '0, '0);

		wait_drained();
		send_idle_pct = 28;
		recv_idle_pct = 86;
		send_random(130);

		wait_drained();
		send_idle_pct = 86;
		recv_idle_pct = 28;
		send_random(130);

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		send_random(16);
		send_random(130);

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
